/* rtl/mass_pkg.sv */
`timescale 1ns / 1ps
package mass_pkg;

  localparam int unsigned SumBits  = 64;
  localparam int unsigned CntBits  = 6;
  localparam int unsigned AbsBits  = 58;
  localparam int unsigned OutAbsW  = 57;

  typedef struct packed {
    logic [51:0] value;
    logic        last;
  } in_word_t;

  typedef struct packed {
    logic [56:0] min_abs_sum;
    logic [5:0]  subset_size;
    logic        overflowed;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_ENUM_LO,
    ST_ENUM_HI,
    ST_SORT_RD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_DEDUP_RD,
    ST_DEDUP_WR,
    ST_SRCH_RD,
    ST_SRCH_STEP,
    ST_SRCH_PROBE,
    ST_SRCH_PROBE2,
    ST_OUT
  } state_e;

endpackage

/* rtl/mass_ram.sv */
`timescale 1ns / 1ps
module mass_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/min_abs_subset_sum.sv */
`timescale 1ns / 1ps
// Smallest absolute nonempty subset sum of a loaded set.
// Input channel (in_valid_i/in_ready_o/in_word_i): one signed element per
// word; a word with last set closes the set and starts the search. Words
// beyond MaxItems are dropped and flagged in the result.
// Output channel (out_valid_o/out_ready_i/out_word_o): one result word per
// set: minimum |sum|, fewest elements reaching it, and the overflow flag.
// Loading accepts one word per cycle. After last the block enumerates the
// lower half sums into the lower RAM and the upper half sums into the upper
// RAM, walking the index bits serially. It then sorts the lower table with an
// in-memory bubble pass loop, compacts duplicates, and runs a binary search
// into the lower table for every nonempty upper sum; with an empty lower
// table it goes straight to output. After the search the block enters
// ST_OUT, which registers the result word once the output register is free.
// The input is not ready from last until the result moves into the output
// register; a stalled receiver holds that register and blocks the input only
// when the next result is ready. Reset empties the set, clears the overflow
// flag and drops any pending result; the RAMs are rewritten by every search.
module min_abs_subset_sum #(
  parameter int unsigned MaxItems       = 32,
  parameter int unsigned HalfTableDepth = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mass_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mass_pkg::out_word_t  out_word_o
);
  import mass_pkg::*;

  localparam int unsigned IdxW = $clog2(MaxItems);
  localparam int unsigned NumW = $clog2(MaxItems + 1);
  localparam int unsigned AW   = $clog2(HalfTableDepth);
  localparam int unsigned TW   = AW + 1;
  localparam int unsigned EW   = SumBits + CntBits;

  state_e state_q, state_d;

  // element store: small register array, indexed by the enumeration bit
  logic signed [SumBits-1:0] elem_q [MaxItems];
  logic [NumW-1:0] n_q, n_d;
  logic            ovf_q, ovf_d;
  logic [NumW-1:0] lh_q, lh_d, rh_q, rh_d;
  logic [TW-1:0]   i_q, i_d, tot_q, tot_d, m_q, m_d, j_q, j_d;
  logic            swapped_q, swapped_d;
  logic [TW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic signed [SumBits-1:0] acc_q, acc_d;
  logic [CntBits-1:0]        cnt_q, cnt_d;
  logic [NumW-1:0]           bit_q, bit_d;
  logic [EW-1:0]   a_q, a_d, r_q, r_d;
  logic [AbsBits-1:0] best_q, best_d;
  logic [CntBits-1:0] bsz_q, bsz_d;
  logic            out_v_q, out_v_d;
  out_word_t       out_q, out_d;

  // RAM ports
  logic          lwe, uwe;
  logic [AW-1:0] lwa, lra, uwa, ura;
  logic [EW-1:0] lwd, lrd, uwd, urd;

  mass_ram #(.Width(EW), .Depth(HalfTableDepth)) u_lower (
    .clk_i, .we_i(lwe), .waddr_i(lwa), .wdata_i(lwd), .raddr_i(lra), .rdata_o(lrd));
  mass_ram #(.Width(EW), .Depth(HalfTableDepth)) u_upper (
    .clk_i, .we_i(uwe), .waddr_i(uwa), .wdata_i(uwd), .raddr_i(ura), .rdata_o(urd));

  function automatic logic [AbsBits-1:0] mag(input logic signed [SumBits-1:0] x);
    logic [SumBits-1:0] u;
    u = x[SumBits-1] ? SumBits'(-x) : SumBits'(x);
    return u[AbsBits-1:0];
  endfunction

  logic signed [SumBits-1:0] in_ext;
  assign in_ext = SumBits'(signed'(in_word_i.value));

  logic in_fire;
  assign in_ready_o = (state_q == ST_LOAD);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && (n_q < NumW'(MaxItems))) begin
      elem_q[n_q[IdxW-1:0]] <= in_ext;
    end
  end

  // sum/count fields of RAM words
  logic signed [SumBits-1:0] a_s, r_s, lrd_s;
  logic [CntBits-1:0] a_c, r_c, lrd_c;
  assign a_s = a_q[EW-1:CntBits];   assign a_c = a_q[CntBits-1:0];
  assign r_s = r_q[EW-1:CntBits];   assign r_c = r_q[CntBits-1:0];
  assign lrd_s = lrd[EW-1:CntBits]; assign lrd_c = lrd[CntBits-1:0];

  // candidate evaluation
  logic               off_en;
  logic [AbsBits-1:0] off_a;
  logic [CntBits-1:0] off_c;
  logic [TW-1:0]      mid;
  logic [TW-1:0]      span;
  logic [NumW-1:0]    hcnt;
  logic [63:0]        tfull;
  logic [TW-1:0]      pick;

  always_comb begin
    state_d = state_q; n_d = n_q; ovf_d = ovf_q; lh_d = lh_q; rh_d = rh_q;
    i_d = i_q; tot_d = tot_q; m_d = m_q; j_d = j_q; swapped_d = swapped_q;
    lo_d = lo_q; hi_d = hi_q; acc_d = acc_q; cnt_d = cnt_q; bit_d = bit_q;
    a_d = a_q; r_d = r_q; best_d = best_q; bsz_d = bsz_q;
    out_v_d = out_v_q & ~out_ready_i; out_d = out_q;
    lwe = 1'b0; uwe = 1'b0; lwa = '0; uwa = '0; lwd = '0; uwd = '0;
    lra = '0; ura = '0;
    off_en = 1'b0; off_a = '0; off_c = '0;
    span = hi_q - lo_q;
    mid = lo_q + (span >> 1);
    hcnt = '0; tfull = '0;
    pick = i_q >> bit_q;

    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          if (n_q < NumW'(MaxItems)) n_d = n_q + 1'b1;
          else ovf_d = 1'b1;
          if (in_word_i.last) begin
            hcnt = ((n_q < NumW'(MaxItems)) ? n_q + 1'b1 : n_q);
            lh_d = hcnt >> 1;
            rh_d = hcnt - (hcnt >> 1);
            tfull = 64'(1) << (hcnt >> 1);
            tot_d = (tfull > 64'(HalfTableDepth)) ? TW'(HalfTableDepth) : TW'(tfull);
            best_d = '1; bsz_d = '1;
            i_d = '0; m_d = '0; bit_d = '0; acc_d = '0; cnt_d = '0;
            state_d = ST_ENUM_LO;
          end
        end
      end
      // walk the index bits serially for each subset, then store it
      ST_ENUM_LO, ST_ENUM_HI: begin
        hcnt = (state_q == ST_ENUM_LO) ? lh_q : rh_q;
        if (bit_q < hcnt) begin
          if (pick[0]) begin
            acc_d = acc_q + elem_q[IdxW'(((state_q == ST_ENUM_LO) ? 0 : lh_q) + bit_q)];
            cnt_d = cnt_q + 1'b1;
          end
          bit_d = bit_q + 1'b1;
        end else begin
          if (cnt_q != 0) begin
            off_en = 1'b1; off_a = mag(acc_q); off_c = cnt_q;
          end
          if (state_q == ST_ENUM_LO) begin
            // keep only nonempty lower subsets, packed from 0
            if (cnt_q != 0) begin
              lwe = 1'b1; lwa = m_q[AW-1:0]; lwd = {acc_q, cnt_q};
              m_d = m_q + 1'b1;
            end
          end else begin
            uwe = 1'b1; uwa = i_q[AW-1:0]; uwd = {acc_q, cnt_q};
          end
          bit_d = '0; acc_d = '0; cnt_d = '0;
          if (i_q + 1'b1 == tot_q) begin
            i_d = '0;
            if (state_q == ST_ENUM_LO) begin
              tfull = 64'(1) << rh_q;
              tot_d = (tfull > 64'(HalfTableDepth)) ? TW'(HalfTableDepth) : TW'(tfull);
              state_d = ST_ENUM_HI;
            end else begin
              j_d = '0; swapped_d = 1'b0; lo_d = '0;
              state_d = (m_q > 1) ? ST_SORT_RD : ST_DEDUP_RD;
              if (m_q == 0) state_d = ST_OUT;
            end
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      // sort: pass over adjacent pairs; a_q holds entry j, fetch j+1
      ST_SORT_RD: begin
        lra = j_q[AW-1:0];
        state_d = ST_SORT_CMP;
        i_d = j_q + 1'b1;
      end
      ST_SORT_CMP: begin
        a_d = lrd;
        lra = i_q[AW-1:0];
        state_d = ST_SORT_WR;
      end
      ST_SORT_WR: begin
        if ((lrd_s < a_s) || ((lrd_s == a_s) && (lrd_c < a_c))) begin
          lwe = 1'b1; lwa = j_q[AW-1:0]; lwd = lrd;
          r_d = a_q; swapped_d = 1'b1;
          state_d = ST_SRCH_PROBE2; // second write of the swap
        end else begin
          state_d = ST_SORT_RD;
        end
        j_d = j_q + 1'b1;
        if (!((lrd_s < a_s) || ((lrd_s == a_s) && (lrd_c < a_c))) && (j_q + 2'd2 >= m_q))
        begin
          j_d = '0; swapped_d = 1'b0;
          state_d = swapped_q ? ST_SORT_RD : ST_DEDUP_RD;
          i_d = '0; lo_d = '0;
        end
      end
      // dedup: i reads, lo writes; a_q keeps last kept sum
      ST_DEDUP_RD: begin
        lra = i_q[AW-1:0];
        state_d = ST_DEDUP_WR;
      end
      ST_DEDUP_WR: begin
        if (lo_q == 0 || lrd_s != a_s) begin
          lwe = 1'b1; lwa = lo_q[AW-1:0]; lwd = lrd;
          a_d = lrd; lo_d = lo_q + 1'b1;
        end
        i_d = i_q + 1'b1;
        if (i_q + 1'b1 == m_q) begin
          m_d = (lo_q == 0 || lrd_s != a_s) ? lo_q + 1'b1 : lo_q;
          i_d = '0;
          state_d = ST_SRCH_RD;
        end else begin
          state_d = ST_DEDUP_RD;
        end
      end
      ST_SRCH_RD: begin
        ura = i_q[AW-1:0];
        lo_d = '0; hi_d = m_q;
        state_d = ST_SRCH_STEP;
        j_d = '0;
      end
      ST_SRCH_STEP: begin
        if (j_q == 0) begin
          r_d = urd; j_d = TW'(1);
        end else if (r_c == 0) begin
          state_d = ST_SRCH_PROBE;
          j_d = '0;
        end else if (lo_q < hi_q) begin
          lra = mid[AW-1:0];
          j_d = TW'(2);
          if (j_q == 2) begin
            if (lrd_s < -r_s) lo_d = mid + 1'b1;
            else hi_d = mid;
            j_d = TW'(1);
          end
        end else begin
          state_d = ST_SRCH_PROBE;
          lra = lo_q[AW-1:0];
          j_d = TW'(1);
        end
        // j==1 issues the read of mid and j==2 compares it; mid follows the new bounds next cycle
        if (j_q == 1 && r_c != 0 && lo_q < hi_q) j_d = TW'(2);
      end
      ST_SRCH_PROBE: begin
        if (r_c != 0 && j_q == 1) begin
          if (lo_q < m_q) begin
            off_en = 1'b1; off_a = mag(lrd_s + r_s); off_c = r_c + lrd_c;
          end
          lra = lo_q[AW-1:0] - 1'b1;
          j_d = TW'(2);
        end else begin
          if (r_c != 0 && lo_q > 0) begin
            off_en = 1'b1; off_a = mag(lrd_s + r_s); off_c = r_c + lrd_c;
          end
          if (i_q + 1'b1 == tot_q) state_d = ST_OUT;
          else begin
            i_d = i_q + 1'b1;
            state_d = ST_SRCH_RD;
          end
        end
      end
      ST_SRCH_PROBE2: begin
        // finish a sort swap: write the old entry j at j+1
        lwe = 1'b1; lwa = j_q[AW-1:0]; lwd = r_q;
        state_d = ST_SORT_RD;
        if (j_q + 1'b1 >= m_q) begin
          j_d = '0; swapped_d = 1'b0; state_d = ST_SORT_RD;
        end
      end
      ST_OUT: begin
        // park the result once the output register is free, then reopen input
        if (!out_v_q || out_ready_i) begin
          out_d.min_abs_sum = best_q[OutAbsW-1:0];
          out_d.subset_size = bsz_q;
          out_d.overflowed  = ovf_q;
          out_v_d = 1'b1; n_d = '0; ovf_d = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase

    if (off_en && ((off_a < best_q) || ((off_a == best_q) && (off_c < bsz_q)))) begin
      best_d = off_a; bsz_d = off_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; n_q <= '0; ovf_q <= 1'b0; out_v_q <= 1'b0;
      best_q <= '1; bsz_q <= '1; out_q <= '0;
    end else begin
      state_q <= state_d; n_q <= n_d; ovf_q <= ovf_d; out_v_q <= out_v_d;
      best_q <= best_d; bsz_q <= bsz_d; out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lh_q <= lh_d; rh_q <= rh_d; i_q <= i_d; tot_q <= tot_d; m_q <= m_d;
    j_q <= j_d; swapped_q <= swapped_d; lo_q <= lo_d; hi_q <= hi_d;
    acc_q <= acc_d; cnt_q <= cnt_d; bit_q <= bit_d; a_q <= a_d; r_q <= r_d;
  end
endmodule

/* test/tb_min_abs_subset_sum.sv */
`timescale 1ns / 1ps
module tb_min_abs_subset_sum;
  import mass_pkg::*;

  localparam int unsigned CapItems = 32;
  localparam longint unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned LongHold = 20000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  min_abs_subset_sum dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_word_o (out_word)
  );

  // Words waiting for the driver, the set being collected, and the result
  // words the set search is expected to produce.
  in_word_t  pending_words[$];
  longint    open_set[$];
  bit        open_overflow;
  out_word_t expected_results[$];

  int unsigned     error_count;
  int unsigned     results_seen;
  longint unsigned cycle_count;
  int unsigned     gap_left;
  int unsigned     burst_left;
  int unsigned     hold_left;
  bit              hold_done;
  int unsigned     stall_phase;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // Exhaustive search over every nonempty subset; sets stay small enough here.
  function automatic out_word_t smallest_abs_subset(input longint vals[$], input bit ovf);
    out_word_t       r;
    longint          s;
    longint unsigned a;
    longint unsigned best_a;
    int unsigned     c;
    int unsigned     best_c;
    int unsigned     n;
    best_a = '1;
    best_c = 63;
    n = vals.size();
    for (longint unsigned m = 1; m < (64'd1 << n); m++) begin
      s = 0;
      c = 0;
      for (int unsigned j = 0; j < n; j++) begin
        if (m[j]) begin
          s += vals[j];
          c++;
        end
      end
      a = (s < 0) ? longint'(-s) : longint'(s);
      if (a < best_a || (a == best_a && c < best_c)) begin
        best_a = a;
        best_c = c;
      end
    end
    r.min_abs_sum = best_a[56:0];
    r.subset_size = best_c[5:0];
    r.overflowed  = ovf;
    return r;
  endfunction

  function automatic logic [51:0] rand_value(input int unsigned kind);
    logic [51:0] v;
    case (kind)
      0: v = 52'({$urandom(), $urandom()});
      1: v = 52'($signed(($urandom_range(0, 40)) - 20));
      2: v = 52'($signed(longint'($urandom_range(0, 2000000)) - 1000000));
      default: v = 52'({$urandom(), $urandom()} >> $urandom_range(0, 51));
    endcase
    return v;
  endfunction

  task automatic queue_set(input logic [51:0] vals[$]);
    in_word_t w;
    foreach (vals[i]) begin
      w.value = vals[i];
      w.last  = (i == vals.size() - 1);
      pending_words.push_back(w);
    end
  endtask

  // Driver: bursts of words with random gaps; hold payload until accepted.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_word    <= '0;
      gap_left   <= 0;
      burst_left <= 4;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_words.size() > 0) begin
        in_valid <= 1'b1;
        in_word  <= pending_words.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here; start it once a few results are in.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen == 3) begin
      hold_left <= LongHold;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver: alternate stretches of always-ready and random stalls.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready   <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (hold_left > 1 || (!hold_done && results_seen == 3)) begin
        out_ready <= 1'b0;
      end else if (stall_phase[6]) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Monitor: predict on each accepted input word, check each accepted result.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (open_set.size() < CapItems) begin
          open_set.push_back(longint'($signed(in_word.value)));
        end else begin
          open_overflow = 1'b1;
        end
        if (in_word.last) begin
          expected_results.push_back(smallest_abs_subset(open_set, open_overflow));
          open_set.delete();
          open_overflow = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_word.min_abs_sum, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_word.min_abs_sum !== want.min_abs_sum)
            report_mismatch("min_abs_sum", out_word.min_abs_sum, want.min_abs_sum);
          if (out_word.subset_size !== want.subset_size)
            report_mismatch("subset_size", out_word.subset_size, want.subset_size);
          if (out_word.overflowed !== want.overflowed)
            report_mismatch("overflowed", out_word.overflowed, want.overflowed);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_min_abs_subset_sum: done, errors");
      $finish;
    end
  end

  initial begin
    logic [51:0]  vals[$];
    int unsigned  items;
    int unsigned  n;
    int unsigned  kind;
    error_count   = 0;
    results_seen  = 0;
    cycle_count   = 0;
    open_overflow = 1'b0;
    rst_n         = 1'b0;

    // Directed sets: field extremes, zero, exact cancel, and a tie at zero
    // where the two-element subset must win over the three-element one.
    vals = '{52'h7_FFFF_FFFF_FFFF};                   queue_set(vals);
    vals = '{52'h8_0000_0000_0000};                   queue_set(vals);
    vals = '{52'd0};                                  queue_set(vals);
    vals = '{52'h8_0000_0000_0000, 52'h7_FFFF_FFFF_FFFF}; queue_set(vals);
    vals = '{52'd1, 52'd1, -52'sd2, 52'd4, -52'sd4};  queue_set(vals);
    vals = '{52'h8_0000_0000_0000, 52'h8_0000_0000_0000,
             52'h8_0000_0000_0000};                   queue_set(vals);
    vals = '{52'd7, -52'sd5, 52'd9, 52'd3, -52'sd11, 52'd2}; queue_set(vals);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Random sets: mostly small, a few larger; the sort grows with the
    // square of the lower-half table, so sizes stay modest.
    items = 0;
    while (items < 100) begin
      case ($urandom_range(0, 19))
        0:       n = 12;
        1:       n = ($urandom_range(0, 1) == 0) ? 14 : 10;
        default: n = $urandom_range(1, 8);
      endcase
      kind = $urandom_range(0, 3);
      vals.delete();
      for (int unsigned i = 0; i < n; i++)
        vals.push_back(rand_value(($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : kind));
      queue_set(vals);
      items += n;
    end

    wait (pending_words.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb_min_abs_subset_sum: done, clean");
    end else begin
      $display("tb_min_abs_subset_sum: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mass_pkg.sv
rtl/mass_ram.sv
rtl/min_abs_subset_sum.sv
test/tb_min_abs_subset_sum.sv
